@@ hw/rtl/ecef_ltp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ECEF to local tangent plane: shared package
// Widths, operation and register codes, beat structs and the matrix type
// used across the rotation pipeline.
// ----------------------------------------------------------------------------
package ecef_ltp_pkg;

    // Field widths.
    localparam int COORD_W             = 32;
    localparam int TRIG_W              = 22;
    localparam int MAT_W               = 32;
    localparam int CFG_DATA_W          = 32;
    localparam int CFG_INDEX_W         = 3;
    localparam int TRIG_FRAC_BITS_DEF  = 20;
    localparam int NUM_PROD            = 8;

    // Reset value of the cosines: one in Q20.
    localparam logic signed [TRIG_W-1:0] TRIG_ONE = 22'sd1048576;

    // Product slots, one per matrix entry and coordinate pair.
    localparam int PROD_M0X = 0;
    localparam int PROD_M1Y = 1;
    localparam int PROD_M3X = 2;
    localparam int PROD_M4Y = 3;
    localparam int PROD_M5Z = 4;
    localparam int PROD_M6X = 5;
    localparam int PROD_M7Y = 6;
    localparam int PROD_M8Z = 7;

    typedef enum logic [1:0] {
        OP_ENU_POINT  = 2'd0,
        OP_NED_POINT  = 2'd1,
        OP_ENU_VECTOR = 2'd2,
        OP_NED_VECTOR = 2'd3
    } op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SINE_LAT   = 3'd0,
        REG_COSINE_LAT = 3'd1,
        REG_SINE_LON   = 3'd2,
        REG_COSINE_LON = 3'd3,
        REG_ORIGIN_X   = 3'd4,
        REG_ORIGIN_Y   = 3'd5,
        REG_ORIGIN_Z   = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        op_t                       op;
        logic signed [COORD_W-1:0] in_x;
        logic signed [COORD_W-1:0] in_y;
        logic signed [COORD_W-1:0] in_z;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_first;
        logic signed [COORD_W-1:0] out_second;
        logic signed [COORD_W-1:0] out_third;
    } out_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } vec_t;

    // Rotation matrix; m2 is always zero and is not stored.
    typedef struct packed {
        logic signed [MAT_W-1:0] m0;
        logic signed [MAT_W-1:0] m1;
        logic signed [MAT_W-1:0] m3;
        logic signed [MAT_W-1:0] m4;
        logic signed [MAT_W-1:0] m5;
        logic signed [MAT_W-1:0] m6;
        logic signed [MAT_W-1:0] m7;
        logic signed [MAT_W-1:0] m8;
    } matrix_t;

    // Load strobes for the two stages of the summing unit.
    typedef struct packed {
        logic s3;
        logic s4;
    } sum_load_t;

    function automatic logic is_point(input op_t op);
        return (op == OP_ENU_POINT) || (op == OP_NED_POINT);
    endfunction

    function automatic logic is_ned(input op_t op);
        return (op == OP_NED_POINT) || (op == OP_NED_VECTOR);
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/ecef_to_local_tangent_plane.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ECEF to local tangent plane rotation
// Turns ECEF points or vectors in centimetres into ENU or NED coordinates
// about a configured origin, in a four-stage pipeline.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Payload
//  in        input      in_valid / in_stall       in_item  (op, in_x, in_y, in_z)
//  out       output     out_valid / out_stall     out_item (first, second, third)
//  cfg       input      cfg_write_en              cfg_index, cfg_data
//
//  One beat is accepted per cycle while in_stall is low; a result passes
//  through four register stages: origin subtract, multipliers, row sums,
//  output register.
//  The multiplier stage sets the cycle time.
//  Reset clears the stage valid bits and loads the default configuration;
//  the derived matrix follows the registers in the next cycle.
//  A stalled output holds each full stage with no empty stage after it; empty stages keep filling.
// ----------------------------------------------------------------------------
module ecef_to_local_tangent_plane
    import ecef_ltp_pkg::*;
#(
    parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_item_t               in_item,
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_item_t              out_item,
    input  logic                   cfg_write_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int ACC_W = TRIG_FRAC_BITS + COORD_W;

    vec_t                           origin;
    matrix_t                        matrix;

    logic                           s1_valid_reg;
    logic                           s2_valid_reg;
    logic                           s3_valid_reg;
    logic                           s4_valid_reg;
    logic                           s1_ready;
    logic                           s2_ready;
    logic                           s3_ready;
    logic                           s4_ready;

    op_t                            s1_op_reg;
    vec_t                           s1_vec_reg;
    vec_t                           s1_vec_next;
    op_t                            s2_op;
    logic [NUM_PROD-1:0][ACC_W-1:0] s2_prod;
    sum_load_t                      sum_load;

    // Configuration registers and derived matrix.
    ecef_ltp_cfg #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .origin       (origin),
        .matrix       (matrix)
    );

    // A stage may load when it is empty or its contents move on.
    assign s4_ready = !s4_valid_reg || !out_stall;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_stall = !s1_ready;

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_ready)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    // First stage: points are taken relative to the origin, wrapping at 32 bits.
    always_comb
    begin
        if (is_point(in_item.op))
        begin
            s1_vec_next.x = in_item.in_x - origin.x;
            s1_vec_next.y = in_item.in_y - origin.y;
            s1_vec_next.z = in_item.in_z - origin.z;
        end
        else
        begin
            s1_vec_next.x = in_item.in_x;
            s1_vec_next.y = in_item.in_y;
            s1_vec_next.z = in_item.in_z;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_op_reg  <= in_item.op;
            s1_vec_reg <= s1_vec_next;
        end
    end

    // Second stage: matrix products.
    ecef_ltp_mult #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_mult (
        .clk    (clk),
        .load   (s2_ready),
        .op     (s1_op_reg),
        .vec    (s1_vec_reg),
        .matrix (matrix),
        .op_out (s2_op),
        .prod   (s2_prod)
    );

    // Third and fourth stages: row sums and output formatting.
    assign sum_load.s3 = s3_ready;
    assign sum_load.s4 = s4_ready;

    ecef_ltp_sum #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_sum (
        .clk  (clk),
        .load (sum_load),
        .op   (s2_op),
        .prod (s2_prod),
        .item (out_item)
    );

    assign out_valid = s4_valid_reg;

    // The input is stalled only when the first stage holds a beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with an empty first stage");

    // With the output free every stage moves, so nothing stalls the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while the output is free");

    // A held first stage keeps its beat unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_ready) |=>
            (s1_valid_reg && $stable(s1_vec_reg) && $stable(s1_op_reg)))
        else $error("first stage lost or changed a held beat");

endmodule
`default_nettype wire

@@ hw/rtl/ecef_ltp_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ECEF to local tangent plane: configuration registers
// Holds the origin and the four trig values, and keeps a registered copy
// of the rotation matrix derived from them.
// ----------------------------------------------------------------------------
module ecef_ltp_cfg
    import ecef_ltp_pkg::*;
#(
    parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output vec_t                   origin,
    output matrix_t                matrix
);

    localparam int EXT_W  = TRIG_W + 1;
    localparam int PROD_W = 2 * EXT_W;

    logic signed [TRIG_W-1:0]  sin_lat_reg;
    logic signed [TRIG_W-1:0]  cos_lat_reg;
    logic signed [TRIG_W-1:0]  sin_lon_reg;
    logic signed [TRIG_W-1:0]  cos_lon_reg;
    vec_t                      origin_reg;
    matrix_t                   matrix_reg;
    matrix_t                   matrix_next;

    logic signed [EXT_W-1:0]   sin_lat_ext;
    logic signed [EXT_W-1:0]   cos_lat_ext;
    logic signed [EXT_W-1:0]   sin_lon_ext;
    logic signed [EXT_W-1:0]   cos_lon_ext;
    logic signed [EXT_W-1:0]   neg_sin_lat;
    logic signed [EXT_W-1:0]   neg_sin_lon;
    logic signed [PROD_W-1:0]  prod_m3;
    logic signed [PROD_W-1:0]  prod_m4;
    logic signed [PROD_W-1:0]  prod_m6;
    logic signed [PROD_W-1:0]  prod_m7;

    // Scale a trig product back to Q format and keep the low word.
    function automatic logic signed [MAT_W-1:0] scale_entry(
        input logic signed [PROD_W-1:0] p
    );
        logic signed [63:0] wide;
        wide = 64'(p);
        return MAT_W'(wide >>> TRIG_FRAC_BITS);
    endfunction

    // Register writes; an index past the last register is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sin_lat_reg  <= '0;
            cos_lat_reg  <= TRIG_ONE;
            sin_lon_reg  <= '0;
            cos_lon_reg  <= TRIG_ONE;
            origin_reg   <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SINE_LAT:   sin_lat_reg  <= cfg_data[TRIG_W-1:0];
                REG_COSINE_LAT: cos_lat_reg  <= cfg_data[TRIG_W-1:0];
                REG_SINE_LON:   sin_lon_reg  <= cfg_data[TRIG_W-1:0];
                REG_COSINE_LON: cos_lon_reg  <= cfg_data[TRIG_W-1:0];
                REG_ORIGIN_X:   origin_reg.x <= cfg_data[COORD_W-1:0];
                REG_ORIGIN_Y:   origin_reg.y <= cfg_data[COORD_W-1:0];
                REG_ORIGIN_Z:   origin_reg.z <= cfg_data[COORD_W-1:0];
                default:        ;
            endcase
        end
    end

    // Trig values widened by one bit so that negation cannot overflow.
    assign sin_lat_ext = EXT_W'(sin_lat_reg);
    assign cos_lat_ext = EXT_W'(cos_lat_reg);
    assign sin_lon_ext = EXT_W'(sin_lon_reg);
    assign cos_lon_ext = EXT_W'(cos_lon_reg);
    assign neg_sin_lat = -sin_lat_ext;
    assign neg_sin_lon = -sin_lon_ext;

    // Products of latitude and longitude terms.
    assign prod_m3 = neg_sin_lat * cos_lon_ext;
    assign prod_m4 = neg_sin_lat * sin_lon_ext;
    assign prod_m6 = cos_lat_ext * cos_lon_ext;
    assign prod_m7 = cos_lat_ext * sin_lon_ext;

    // Matrix entries before the register.
    always_comb
    begin
        matrix_next.m0 = MAT_W'(neg_sin_lon);
        matrix_next.m1 = MAT_W'(cos_lon_ext);
        matrix_next.m3 = scale_entry(prod_m3);
        matrix_next.m4 = scale_entry(prod_m4);
        matrix_next.m5 = MAT_W'(cos_lat_ext);
        matrix_next.m6 = scale_entry(prod_m6);
        matrix_next.m7 = scale_entry(prod_m7);
        matrix_next.m8 = MAT_W'(sin_lat_ext);
    end

    // The matrix follows the registers in the next cycle, also during reset.
    always_ff @(posedge clk)
    begin
        matrix_reg <= matrix_next;
    end

    assign origin = origin_reg;
    assign matrix = matrix_reg;

endmodule
`default_nettype wire

@@ hw/rtl/ecef_ltp_mult.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ECEF to local tangent plane: product stage
// Forms the eight matrix-by-coordinate products of one beat and registers
// them, cut to the width that the final shift needs.
// ----------------------------------------------------------------------------
module ecef_ltp_mult
    import ecef_ltp_pkg::*;
#(
    parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
)
(
    input  logic                                                clk,
    input  logic                                                load,
    input  op_t                                                 op,
    input  vec_t                                                vec,
    input  matrix_t                                             matrix,
    output op_t                                                 op_out,
    output logic [NUM_PROD-1:0][TRIG_FRAC_BITS+COORD_W-1:0]     prod
);

    localparam int ACC_W = TRIG_FRAC_BITS + COORD_W;
    localparam int FULL_W = MAT_W + COORD_W;

    logic signed [FULL_W-1:0]                   prod_full [NUM_PROD];
    logic [NUM_PROD-1:0][ACC_W-1:0]             prod_reg;
    op_t                                        op_reg;

    // One multiplier per matrix entry in use.
    always_comb
    begin
        prod_full[PROD_M0X] = $signed(matrix.m0) * $signed(vec.x);
        prod_full[PROD_M1Y] = $signed(matrix.m1) * $signed(vec.y);
        prod_full[PROD_M3X] = $signed(matrix.m3) * $signed(vec.x);
        prod_full[PROD_M4Y] = $signed(matrix.m4) * $signed(vec.y);
        prod_full[PROD_M5Z] = $signed(matrix.m5) * $signed(vec.z);
        prod_full[PROD_M6X] = $signed(matrix.m6) * $signed(vec.x);
        prod_full[PROD_M7Y] = $signed(matrix.m7) * $signed(vec.y);
        prod_full[PROD_M8Z] = $signed(matrix.m8) * $signed(vec.z);
    end

    // Only the low bits up to the top of the shifted result matter.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            op_reg <= op;
            for (int i = 0; i < NUM_PROD; i++)
            begin
                prod_reg[i] <= prod_full[i][ACC_W-1:0];
            end
        end
    end

    assign op_out = op_reg;
    assign prod   = prod_reg;

endmodule
`default_nettype wire

@@ hw/rtl/ecef_ltp_sum.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ECEF to local tangent plane: sum and output stages
// Adds the products of each row, shifts by the fraction width, then orders
// and negates the axes for the requested frame in the output register.
// ----------------------------------------------------------------------------
module ecef_ltp_sum
    import ecef_ltp_pkg::*;
#(
    parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
)
(
    input  logic                                            clk,
    input  sum_load_t                                       load,
    input  op_t                                             op,
    input  logic [NUM_PROD-1:0][TRIG_FRAC_BITS+COORD_W-1:0] prod,
    output out_item_t                                       item
);

    localparam int ACC_W = TRIG_FRAC_BITS + COORD_W;

    logic [ACC_W-1:0]          sum_east;
    logic [ACC_W-1:0]          sum_north;
    logic [ACC_W-1:0]          sum_up;
    logic signed [COORD_W-1:0] east_reg;
    logic signed [COORD_W-1:0] north_reg;
    logic signed [COORD_W-1:0] up_reg;
    logic                      ned_reg;
    out_item_t                 item_reg;
    out_item_t                 item_next;

    // Row sums wrap at the accumulator width.
    assign sum_east  = prod[PROD_M0X] + prod[PROD_M1Y];
    assign sum_north = prod[PROD_M3X] + prod[PROD_M4Y] + prod[PROD_M5Z];
    assign sum_up    = prod[PROD_M6X] + prod[PROD_M7Y] + prod[PROD_M8Z];

    // Sum stage: drop the fraction bits.
    always_ff @(posedge clk)
    begin
        if (load.s3)
        begin
            east_reg  <= sum_east[ACC_W-1:TRIG_FRAC_BITS];
            north_reg <= sum_north[ACC_W-1:TRIG_FRAC_BITS];
            up_reg    <= sum_up[ACC_W-1:TRIG_FRAC_BITS];
            ned_reg   <= is_ned(op);
        end
    end

    // NED swaps the horizontal axes and turns up into down.
    always_comb
    begin
        if (ned_reg)
        begin
            item_next.out_first  = north_reg;
            item_next.out_second = east_reg;
            item_next.out_third  = -up_reg;
        end
        else
        begin
            item_next.out_first  = east_reg;
            item_next.out_second = north_reg;
            item_next.out_third  = up_reg;
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (load.s4)
        begin
            item_reg <= item_next;
        end
    end

    assign item = item_reg;

endmodule
`default_nettype wire
